FILE: rtl/core/sync_framed_byte_deframer_defines.svh
// Assertion macros shared by the sync framed byte deframer modules.
// Included by the controller and the datapath; no other dependencies.
`ifndef SYNC_FRAMED_BYTE_DEFRAMER_DEFINES_SVH
`define SYNC_FRAMED_BYTE_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define SFBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfbd assertion failed");
`define SFBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfbd assertion failed");
`else
`define SFBD_ASSERT_NOW(label, clk, rst, ante, cons)
`define SFBD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/sfbd_pkg.sv
// Shared types and constants of the sync framed byte deframer.
// Used by the controller, the datapath and the top level; no dependencies.
package sfbd_pkg;

  localparam int ByteW = 8;
  localparam int OutDataW = 32;

  localparam logic [ByteW-1:0] SyncFirstReset = 8'd170;
  localparam logic [ByteW-1:0] SyncSecondReset = 8'd85;

  localparam int CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] RegSyncFirst = 1'b0;
  localparam logic [CfgIndexW-1:0] RegSyncSecond = 1'b1;

  typedef struct packed {
    logic ld_type;
    logic ld_len;
    logic st_byte;
    logic emit_start;
    logic rd;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic sync0_hit;
    logic sync1_hit;
    logic len_big;
    logic len_zero;
    logic fill_done;
    logic sum_hit;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/sfbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sfbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/sfbd_ctrl.sv
// Controller of the sync framed byte deframer: frame parse phases and emit loop.
// Depends on sfbd_pkg and the assertion macro header.
`include "sync_framed_byte_deframer_defines.svh"
module sfbd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  sfbd_pkg::status_t st,
  output sfbd_pkg::cmd_t    cmd
);
  import sfbd_pkg::*;

  typedef enum logic [2:0] {
    WAIT_S0,
    WAIT_S1,
    GET_TYPE,
    GET_LEN,
    GET_PAYLOAD,
    GET_CHECK,
    EMIT_RD,
    EMIT_WR
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign take = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      WAIT_S0: begin
        if (take) begin
          state_next = st.sync0_hit ? WAIT_S1 : WAIT_S0;
        end
      end
      WAIT_S1: begin
        if (take) begin
          priority if (st.sync1_hit) begin
            state_next = GET_TYPE;
          end else if (st.sync0_hit) begin
            state_next = WAIT_S1;
          end else begin
            state_next = WAIT_S0;
          end
        end
      end
      GET_TYPE: begin
        if (take) begin
          state_next = GET_LEN;
        end
      end
      GET_LEN: begin
        if (take) begin
          priority if (st.len_big) begin
            state_next = WAIT_S0;
          end else if (st.len_zero) begin
            state_next = GET_CHECK;
          end else begin
            state_next = GET_PAYLOAD;
          end
        end
      end
      GET_PAYLOAD: begin
        if (take && st.fill_done) begin
          state_next = GET_CHECK;
        end
      end
      GET_CHECK: begin
        if (take) begin
          state_next = st.sum_hit ? EMIT_RD : WAIT_S0;
        end
      end
      EMIT_RD: begin
        state_next = EMIT_WR;
      end
      EMIT_WR: begin
        if (st.out_free) begin
          state_next = st.emit_last ? WAIT_S0 : EMIT_RD;
        end
      end
      default: begin
        state_next = WAIT_S0;
      end
    endcase
  end

  always_comb begin
    cmd.ld_type    = take && (state == GET_TYPE);
    cmd.ld_len     = take && (state == GET_LEN);
    cmd.st_byte    = take && (state == GET_PAYLOAD);
    cmd.emit_start = take && (state == GET_CHECK) && st.sum_hit;
    cmd.rd         = (state == EMIT_RD);
    cmd.ld_out     = (state == EMIT_WR) && st.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= WAIT_S0;
      s_tready <= 1'b1;
    end else begin
      state    <= state_next;
      s_tready <= (state_next != EMIT_RD) && (state_next != EMIT_WR);
    end
  end

  `SFBD_ASSERT_NEXT(a_rd_then_wr, clk, rst, state == EMIT_RD, state == EMIT_WR)
  `SFBD_ASSERT_NEXT(a_wr_holds, clk, rst, (state == EMIT_WR) && !st.out_free,
                    state == EMIT_WR)
  `SFBD_ASSERT_NEXT(a_last_frees_input, clk, rst, cmd.ld_out && st.emit_last,
                    s_tready && (state == WAIT_S0))
  `SFBD_ASSERT_NEXT(a_start_emits, clk, rst, cmd.emit_start, state == EMIT_RD)

endmodule

FILE: rtl/core/sfbd_datapath.sv
// Datapath of the sync framed byte deframer: sync registers, frame fields,
// payload store, checksum and output register. Depends on sfbd_pkg, sfbd_ram.
`include "sync_framed_byte_deframer_defines.svh"
module sfbd_datapath #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sfbd_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [sfbd_pkg::ByteW-1:0]        cfg_data,
  input  logic [sfbd_pkg::ByteW-1:0]        s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sfbd_pkg::OutDataW-1:0]     m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast,
  input  sfbd_pkg::cmd_t                    cmd,
  output sfbd_pkg::status_t                 st
);
  import sfbd_pkg::*;

  localparam int FW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [ByteW:0] MaxLen = (ByteW + 1)'(MAX_PAYLOAD);

  logic [ByteW-1:0] sync_first;
  logic [ByteW-1:0] sync_second;
  logic [ByteW-1:0] held_type;
  logic [FW-1:0]    held_length;
  logic [FW-1:0]    fill_count;
  logic [ByteW-1:0] running_sum;
  logic [FW-1:0]    emit_idx;
  logic [ByteW-1:0] rd_data;
  logic [FW:0]      fill_inc;
  logic [FW:0]      emit_inc;

  logic [7:0] out_type;
  logic [6:0] out_length;
  logic [7:0] out_byte;
  logic [5:0] out_index;

  assign fill_inc = {1'b0, fill_count} + (FW + 1)'(1);
  assign emit_inc = {1'b0, emit_idx} + (FW + 1)'(1);

  always_comb begin
    st.sync0_hit = (s_tdata == sync_first);
    st.sync1_hit = (s_tdata == sync_second);
    st.len_big   = ({1'b0, s_tdata} > MaxLen);
    st.len_zero  = (s_tdata == '0);
    st.fill_done = (fill_inc >= {1'b0, held_length});
    st.sum_hit   = (s_tdata == running_sum);
    st.emit_last = (held_length == '0) || (emit_inc == {1'b0, held_length});
    st.out_free  = !m_tvalid || m_tready;
  end

  sfbd_ram #(
    .WIDTH(ByteW),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (cmd.st_byte),
    .waddr(fill_count[AW-1:0]),
    .wdata(s_tdata),
    .re   (cmd.rd),
    .raddr(emit_idx[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SyncFirstReset;
      sync_second <= SyncSecondReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSyncFirst:  sync_first  <= cfg_data;
        RegSyncSecond: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_type   <= '0;
      held_length <= '0;
      fill_count  <= '0;
      running_sum <= '0;
      emit_idx    <= '0;
    end else begin
      if (cmd.ld_type) begin
        held_type   <= s_tdata;
        running_sum <= s_tdata;
      end
      if (cmd.ld_len) begin
        running_sum <= running_sum + s_tdata;
        fill_count  <= '0;
        held_length <= st.len_big ? '0 : s_tdata[FW-1:0];
      end
      if (cmd.st_byte) begin
        running_sum <= running_sum + s_tdata;
        fill_count  <= fill_inc[FW-1:0];
      end
      if (cmd.emit_start) begin
        emit_idx <= '0;
      end
      if (cmd.ld_out) begin
        emit_idx <= emit_inc[FW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.ld_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_type   <= held_type;
      out_length <= 7'(held_length);
      out_byte   <= (held_length == '0) ? '0 : rd_data;
      out_index  <= (held_length == '0) ? '0 : 6'(emit_idx);
      m_tuser    <= (held_length != '0);
      m_tlast    <= st.emit_last;
    end
  end

  assign m_tdata = {3'b000, out_index, out_byte, out_length, out_type};

  `SFBD_ASSERT_NOW(a_store_in_frame, clk, rst, cmd.st_byte, fill_count < held_length)
  `SFBD_ASSERT_NOW(a_emit_in_frame, clk, rst, cmd.ld_out,
                   (emit_idx < held_length) || (held_length == '0))
  `SFBD_ASSERT_NEXT(a_emit_from_zero, clk, rst, cmd.emit_start, emit_idx == '0)
  `SFBD_ASSERT_NEXT(a_load_shows, clk, rst, cmd.ld_out, m_tvalid)

endmodule

FILE: rtl/core/sync_framed_byte_deframer.sv
// Top level of the sync framed byte deframer.
// Depends on sfbd_pkg, sfbd_ctrl, sfbd_datapath and sfbd_ram.
//
// Receives one byte per word on the slave stream and finds frames laid out as
// sync_first, sync_second, type, length, payload, checksum, where the checksum
// is the 8-bit sum of type, length and payload. While a frame is parsed, one
// byte is taken every cycle in which s_tvalid is high. After a matching
// checksum the input stalls while the frame is sent: each result passes
// through a registered read of the payload store, then the output register,
// and any output backpressure lengthens the stall. An empty frame also stalls
// the input for one result. Frames with a bad checksum or a length above
// MAX_PAYLOAD are dropped without a result. The payload store needs no
// clearing after reset, since a result uses only entries written earlier in the same frame.
module sync_framed_byte_deframer #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfbd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [sfbd_pkg::ByteW-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [7:0] rx_byte
  input  logic [sfbd_pkg::ByteW-1:0]     s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] frame_type, [14:8] frame_length, [22:15] payload_byte,
  // [28:23] byte_index, [31:29] zero
  output logic [sfbd_pkg::OutDataW-1:0]  m_tdata,
  // [0] has_data
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import sfbd_pkg::*;

  cmd_t    cmd;
  status_t st;

  sfbd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .st      (st),
    .cmd     (cmd)
  );

  sfbd_datapath #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
